// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mu8d_pkg.sv -----
// ----------------------------------------------------------------------------
// mu8d_pkg
// Types and constants of the modified UTF-8 string decoder.
// ----------------------------------------------------------------------------
package mu8d_pkg;

  localparam int LENGTH_BITS = 16;  // 8 .. 16

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [7:0]             len_hi;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] taken;
    logic [11:0]            partial;
    logic [1:0]             pend;
    logic                   err;
  } mu8d_state_t;

  typedef struct packed {
    logic        emit;
    logic        unit_valid;
    logic [15:0] code_unit;
    logic        last;
    logic        bad;
  } mu8d_result_t;

endpackage

// ----- hw/rtl/mu8d_decode.sv -----
// ----------------------------------------------------------------------------
// mu8d_decode
// Next-state and result logic for one stream byte: header length capture,
// modified UTF-8 sequence assembly, error tracking and record end.
// ----------------------------------------------------------------------------
module mu8d_decode
  import mu8d_pkg::*;
(
  input  mu8d_state_t  state_i,
  input  logic [7:0]   byte_i,
  output mu8d_state_t  state_o,
  output mu8d_result_t res_o
);

  always_comb begin
    logic [LENGTH_BITS-1:0] taken_inc;
    logic [LENGTH_BITS-1:0] rem;
    logic [LENGTH_BITS-1:0] hdr_len;
    logic                   last;
    logic                   valid;
    logic [15:0]            unit;
    logic                   err;

    taken_inc = state_i.taken + 1'b1;
    rem       = (state_i.len >= taken_inc) ? (state_i.len - taken_inc) : '0;
    hdr_len   = LENGTH_BITS'({state_i.len_hi, byte_i});
    last      = (taken_inc >= state_i.len);
    valid     = 1'b0;
    unit      = '0;
    err       = state_i.err;
    state_o   = state_i;
    res_o     = '0;

    unique case (state_i.phase)
      PH_LOW: begin
        state_o.len     = hdr_len;
        state_o.taken   = '0;
        state_o.partial = '0;
        state_o.pend    = '0;
        state_o.err     = 1'b0;
        if (hdr_len == '0) begin
          // empty record ends on its low length byte
          state_o.phase = PH_HIGH;
          res_o.emit    = 1'b1;
          res_o.last    = 1'b1;
        end else begin
          state_o.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        state_o.taken = taken_inc;
        if (!state_i.err) begin
          if (state_i.pend == 2'd0) begin
            if (!byte_i[7]) begin
              valid = 1'b1;
              unit  = {8'h00, byte_i};
            end else if ((byte_i & LEAD2_MASK) == LEAD2_CODE) begin
              if (rem == '0) begin
                err = 1'b1;
              end else begin
                state_o.partial = {7'd0, byte_i[4:0]};
                state_o.pend    = 2'd1;
              end
            end else if ((byte_i & LEAD3_MASK) == LEAD3_CODE) begin
              if (rem <= LENGTH_BITS'(1)) begin
                err = 1'b1;
              end else begin
                state_o.partial = {8'd0, byte_i[3:0]};
                state_o.pend    = 2'd2;
              end
            end else begin
              err = 1'b1;  // stray continuation or 0xF0..0xFF lead
            end
          end else if ((byte_i & CONT_MASK) != CONT_CODE) begin
            err             = 1'b1;
            state_o.pend    = 2'd0;
            state_o.partial = '0;
          end else if (state_i.pend == 2'd1) begin
            valid           = 1'b1;
            unit            = {state_i.partial[9:0], byte_i[5:0]};
            state_o.pend    = 2'd0;
            state_o.partial = '0;
          end else begin
            state_o.partial = {state_i.partial[5:0], byte_i[5:0]};
            state_o.pend    = 2'd1;
          end
        end
        state_o.err = err;
        if (err) begin
          valid = 1'b0;
        end
        res_o.unit_valid = valid;
        res_o.code_unit  = valid ? unit : 16'h0000;
        if (last) begin
          state_o.phase   = PH_HIGH;
          state_o.len     = '0;
          state_o.taken   = '0;
          state_o.partial = '0;
          state_o.pend    = '0;
          state_o.err     = 1'b0;
          res_o.emit      = 1'b1;
          res_o.last      = 1'b1;
          res_o.bad       = err;
        end else begin
          res_o.emit = valid;
        end
      end
      default: begin
        // high length byte; the unused phase code lands here too
        state_o.len_hi = byte_i;
        state_o.phase  = PH_LOW;
      end
    endcase
  end

endmodule

// ----- hw/rtl/modified_utf8_string_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// modified_utf8_string_decoder_unit
// Streaming decoder of length-prefixed modified UTF-8 strings into 16-bit
// code units, one byte per item.
//
//   channel  dir  tdata                  tuser                      tlast
//   in_      in   [7:0] data_byte        -                          -
//   out_     out  [15:0] code_unit       [0] unit_valid, [1] bad    last
//
// One byte per cycle sustained while the output is not stalled; each byte passes
// through the input register, then the result register.
// Bytes that finish no unit and end no record give no output item.
// Reset (rst_n low, synchronous) returns to the expect-high-length state.
// A stalled output holds its item; the input register keeps accepting
// while the result register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module modified_utf8_string_decoder_unit
  import mu8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic [1:0]  out_tuser,  // [0] unit_valid, [1] bad
  output logic        out_tlast
);

  mu8d_state_t  st_r;
  mu8d_state_t  st_nxt;
  mu8d_result_t res;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  logic [15:0] out_unit_r;
  logic [1:0]  out_user_r;
  logic        out_last_r;

  logic out_free;
  logic s1_adv;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_adv;

  mu8d_decode u_decode (
    .state_i (st_r),
    .byte_i  (s1_byte_r),
    .state_o (st_nxt),
    .res_o   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{phase: PH_HIGH, default: '0};
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        st_r        <= st_nxt;
        out_valid_r <= res.emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_adv) begin
      out_unit_r <= res.code_unit;
      out_user_r <= {res.bad, res.unit_valid};
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_unit_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/mu8d_checker.sv -----
// ----------------------------------------------------------------------------
// mu8d_checker
// Port-level checks of the decoder's output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mu8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
               "output item changed while stalled")
  `ASSERT_IMPL(a_unit_zero, clk, rst_n, out_tvalid && !out_tuser[0],
               out_tdata == 16'h0000, "code unit nonzero without unit_valid")
  `ASSERT_IMPL(a_bad_last, clk, rst_n, out_tvalid && out_tuser[1],
               out_tlast && !out_tuser[0], "bad flag outside a failed record end")
  `ASSERT_CLK(a_no_empty, clk, rst_n, !out_tvalid || out_tuser[0] || out_tlast,
              "output item carries neither unit nor record end")

endmodule

bind modified_utf8_string_decoder_unit mu8d_checker u_mu8d_checker (.*);
